### rtl/rebi_pkg.sv
package rebi_pkg;

	localparam int COUNT_WIDTH_DEF = 16;
	localparam int TICK_WIDTH_DEF  = 16;

	localparam int STEP_W     = 16;
	localparam int LP_TICKS_W = 16;
	localparam int APB_DATA_W = 32;
	localparam int APB_ADDR_W = 3;

	localparam logic [LP_TICKS_W-1:0] LP_TICKS_RESET = LP_TICKS_W'(1000);

	typedef enum logic {
		REG_DIR_INVERT = 1'b0,
		REG_LONG_TICKS = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic                  direction_invert;
		logic [LP_TICKS_W-1:0] long_press_ticks;
	} cfg_t;

endpackage

### rtl/rebi_in_if.sv
interface rebi_in_if;
	logic valid;
	logic ready;
	logic line_a;
	logic line_b;
	logic button_level;
	logic query;

	modport source (output valid, output line_a, output line_b, output button_level,
		output query, input ready);
	modport sink (input valid, input line_a, input line_b, input button_level,
		input query, output ready);
endinterface

### rtl/rebi_out_if.sv
interface rebi_out_if;
	logic                              valid;
	logic                              ready;
	logic signed [rebi_pkg::STEP_W-1:0] step_count;
	logic                              short_press;
	logic                              long_press;

	modport source (output valid, output step_count, output short_press,
		output long_press, input ready);
	modport sink (input valid, input step_count, input short_press,
		input long_press, output ready);
endinterface

### rtl/rebi_cfg.sv
module rebi_cfg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [rebi_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [rebi_pkg::APB_DATA_W-1:0] pwdata,
	output logic [rebi_pkg::APB_DATA_W-1:0] prdata,
	output logic                            pready,
	output rebi_pkg::cfg_t                  cfg
);

	rebi_pkg::cfg_t     cfg_q;
	rebi_pkg::reg_idx_t idx;
	logic               wr_en;

	assign idx    = rebi_pkg::reg_idx_t'(paddr[2]);
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.direction_invert <= 1'b0;
			cfg_q.long_press_ticks <= rebi_pkg::LP_TICKS_RESET;
		end else if (wr_en) begin
			unique case (idx)
				rebi_pkg::REG_DIR_INVERT: begin
					cfg_q.direction_invert <= pwdata[0];
				end
				rebi_pkg::REG_LONG_TICKS: begin
					cfg_q.long_press_ticks <= pwdata[rebi_pkg::LP_TICKS_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			rebi_pkg::REG_DIR_INVERT: begin
				prdata = rebi_pkg::APB_DATA_W'(cfg_q.direction_invert);
			end
			rebi_pkg::REG_LONG_TICKS: begin
				prdata = rebi_pkg::APB_DATA_W'(cfg_q.long_press_ticks);
			end
			default: begin
				prdata = '0;
			end
		endcase
	end

endmodule

### rtl/rebi_core.sv
module rebi_core #(
	parameter int COUNT_WIDTH = rebi_pkg::COUNT_WIDTH_DEF,
	parameter int TICK_WIDTH  = rebi_pkg::TICK_WIDTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  rebi_pkg::cfg_t cfg,
	rebi_in_if.sink        sample,
	rebi_out_if.source     result
);

	localparam int CMP_W = (TICK_WIDTH > rebi_pkg::LP_TICKS_W) ? TICK_WIDTH
		: rebi_pkg::LP_TICKS_W;
	localparam logic signed [COUNT_WIDTH-1:0] ACC_MAX = {1'b0, {(COUNT_WIDTH-1){1'b1}}};
	localparam logic signed [COUNT_WIDTH-1:0] ACC_MIN = {1'b1, {(COUNT_WIDTH-1){1'b0}}};
	localparam logic [TICK_WIDTH-1:0] TICK_MAX = '1;

	logic valid_s1;
	logic a_s1, b_s1, btn_s1, query_s1;
	logic valid_s2;
	logic signed [rebi_pkg::STEP_W-1:0] step_count_s2;
	logic short_press_s2, long_press_s2;

	logic tracked_a_q, tracked_b_q, button_prev_q;
	logic signed [COUNT_WIDTH-1:0] acc_q;
	logic short_q, suppress_q;
	logic [TICK_WIDTH-1:0] held_q;

	logic adv;
	logic a_rise, b_rise, step_up, step_dn;
	logic signed [COUNT_WIDTH-1:0] acc_upd;
	logic press_w, release_w, long_w, short_upd, suppress_upd;
	logic [TICK_WIDTH-1:0] held_upd;

	assign adv          = valid_s1 && (!valid_s2 || result.ready);
	assign sample.ready = !valid_s1 || adv;

	// A is handled first, so B sees the updated tracked level of A.
	assign a_rise  = a_s1 && !tracked_a_q && !tracked_b_q;
	assign b_rise  = b_s1 && !tracked_b_q && !a_s1;
	assign step_up = cfg.direction_invert ? b_rise : a_rise;
	assign step_dn = cfg.direction_invert ? a_rise : b_rise;

	always_comb begin
		acc_upd = acc_q;
		if (step_up && acc_q != ACC_MAX) begin
			acc_upd = acc_q + COUNT_WIDTH'(1);
		end else if (step_dn && acc_q != ACC_MIN) begin
			acc_upd = acc_q - COUNT_WIDTH'(1);
		end
	end

	assign press_w   = button_prev_q && !btn_s1;
	assign release_w = !button_prev_q && btn_s1;

	always_comb begin
		if (press_w) begin
			held_upd = '0;
		end else if (held_q == TICK_MAX) begin
			held_upd = held_q;
		end else begin
			held_upd = held_q + TICK_WIDTH'(1);
		end
	end

	assign short_upd    = release_w ? !suppress_q : short_q;
	assign suppress_upd = release_w ? 1'b0 : suppress_q;
	assign long_w       = query_s1 && !btn_s1
		&& (CMP_W'(held_upd) >= CMP_W'(cfg.long_press_ticks));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1      <= 1'b0;
			valid_s2      <= 1'b0;
			tracked_a_q   <= 1'b0;
			tracked_b_q   <= 1'b0;
			button_prev_q <= 1'b1;
			acc_q         <= '0;
			short_q       <= 1'b0;
			suppress_q    <= 1'b0;
			held_q        <= TICK_MAX;
		end else begin
			if (sample.ready) begin
				valid_s1 <= sample.valid;
			end
			if (adv) begin
				valid_s2      <= 1'b1;
				tracked_a_q   <= a_s1;
				tracked_b_q   <= b_s1;
				button_prev_q <= btn_s1;
				acc_q         <= query_s1 ? '0 : acc_upd;
				short_q       <= query_s1 ? 1'b0 : short_upd;
				suppress_q    <= long_w ? 1'b1 : suppress_upd;
				held_q        <= long_w ? TICK_MAX : held_upd;
			end else if (result.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (sample.valid && sample.ready) begin
			a_s1     <= sample.line_a;
			b_s1     <= sample.line_b;
			btn_s1   <= sample.button_level;
			query_s1 <= sample.query;
		end
		if (adv) begin
			step_count_s2  <= rebi_pkg::STEP_W'(acc_upd);
			short_press_s2 <= short_upd;
			long_press_s2  <= long_w;
		end
	end

	assign result.valid       = valid_s2;
	assign result.step_count  = step_count_s2;
	assign result.short_press = short_press_s2;
	assign result.long_press  = long_press_s2;

	a_long_rearms: assert property (@(posedge clk) disable iff (!arst_n)
		adv && long_w |=> held_q == TICK_MAX && suppress_q)
		else $error("long press did not saturate the hold counter");

	a_query_clears: assert property (@(posedge clk) disable iff (!arst_n)
		adv && query_s1 |=> acc_q == '0 && !short_q)
		else $error("query did not clear count and short press");

	a_press_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		adv && press_w && !long_w |=> held_q == '0)
		else $error("press edge did not restart the hold counter");

	a_no_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		adv && !query_s1 && acc_q == ACC_MAX |=> acc_q != ACC_MIN)
		else $error("step count wrapped");

endmodule

### rtl/rotary_encoder_button_interface.sv
// An accepted item is registered in the input register, then its result in the
// result register, from which it leaves when the receiver takes it.
// Throughput: one item per cycle; the encoder, button and query update is one
// pass of logic between the input register and the result register. A result
// held by the receiver stalls the input once both registers are full.
// Reset (arst_n low, asynchronous) clears the count and press flags, marks
// the button released, saturates the hold counter and loads default config.
module rotary_encoder_button_interface #(
	parameter int COUNT_WIDTH = rebi_pkg::COUNT_WIDTH_DEF,
	parameter int TICK_WIDTH  = rebi_pkg::TICK_WIDTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	rebi_in_if.sink                         sample,
	rebi_out_if.source                      result,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [rebi_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [rebi_pkg::APB_DATA_W-1:0] pwdata,
	output logic [rebi_pkg::APB_DATA_W-1:0] prdata,
	output logic                            pready
);

	rebi_pkg::cfg_t cfg;

	rebi_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	rebi_core #(
		.COUNT_WIDTH (COUNT_WIDTH),
		.TICK_WIDTH  (TICK_WIDTH)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.sample (sample),
		.result (result)
	);

endmodule

### tb/rotary_encoder_button_interface_tb.sv
module rotary_encoder_button_interface_tb;

	localparam int     PLAN_LEN     = 25;
	localparam int     RANDOM_ITEMS = 250;
	localparam int     SWEEP_STEPS  = 40;
	localparam int     STALL_LIMIT  = 4000;
	localparam longint ACC_MAX      =
		(longint'(1) <<< (rebi_pkg::COUNT_WIDTH_DEF - 1)) - 1;
	localparam longint ACC_MIN      = -ACC_MAX - 1;

	typedef struct packed {
		logic signed [rebi_pkg::STEP_W-1:0] step_count;
		logic                               short_press;
		logic                               long_press;
	} tick_result_t;

	typedef struct {
		bit                 is_cfg;
		rebi_pkg::reg_idx_t idx;
		int unsigned        val;
		bit                 a;
		bit                 b;
		bit                 btn;
		bit                 q;
		bit                 pinned;
		int                 step;
		bit                 sp;
		bit                 lp;
	} tick_row_t;

	logic                            clk;
	logic                            arst_n;
	logic                            psel;
	logic                            penable;
	logic                            pwrite;
	logic [rebi_pkg::APB_ADDR_W-1:0] paddr;
	logic [rebi_pkg::APB_DATA_W-1:0] pwdata;
	logic [rebi_pkg::APB_DATA_W-1:0] prdata;
	logic                            pready;

	rebi_in_if  sample_if ();
	rebi_out_if result_if ();

	rotary_encoder_button_interface u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.sample  (sample_if),
		.result  (result_if),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	tick_result_t pending_reports [$];
	int           errors        = 0;
	bit           fast_mode     = 0;
	bit           hold_off_req  = 0;
	int           idle_cycles   = 0;

	bit                                  cfg_invert;
	logic [rebi_pkg::LP_TICKS_W-1:0]     cfg_long_ticks;
	bit                                  trk_a;
	bit                                  trk_b;
	bit                                  btn_prev;
	longint                              step_acc;
	bit                                  short_flag;
	bit                                  short_block;
	logic [rebi_pkg::TICK_WIDTH_DEF-1:0] hold_cnt;

	// Rows after the two register writes run with inverted direction and a one-tick threshold.
	tick_row_t plan [PLAN_LEN] = '{
		'{0, rebi_pkg::REG_DIR_INVERT, 0, 0, 0, 1, 1, 1,  0, 0, 0},
		'{0, rebi_pkg::REG_DIR_INVERT, 0, 1, 0, 1, 1, 1,  1, 0, 0},
		'{0, rebi_pkg::REG_DIR_INVERT, 0, 0, 0, 1, 0, 0,  0, 0, 0},
		'{0, rebi_pkg::REG_DIR_INVERT, 0, 0, 1, 1, 1, 1, -1, 0, 0},
		'{0, rebi_pkg::REG_DIR_INVERT, 0, 0, 0, 1, 0, 0,  0, 0, 0},
		'{0, rebi_pkg::REG_DIR_INVERT, 0, 1, 1, 1, 1, 0,  0, 0, 0},
		'{0, rebi_pkg::REG_DIR_INVERT, 0, 0, 0, 1, 0, 0,  0, 0, 0},
		'{0, rebi_pkg::REG_DIR_INVERT, 0, 1, 0, 1, 0, 0,  0, 0, 0},
		'{0, rebi_pkg::REG_DIR_INVERT, 0, 1, 1, 1, 0, 0,  0, 0, 0},
		'{0, rebi_pkg::REG_DIR_INVERT, 0, 0, 1, 1, 0, 0,  0, 0, 0},
		'{0, rebi_pkg::REG_DIR_INVERT, 0, 0, 0, 1, 1, 0,  0, 0, 0},
		'{0, rebi_pkg::REG_DIR_INVERT, 0, 0, 0, 0, 0, 0,  0, 0, 0},
		'{0, rebi_pkg::REG_DIR_INVERT, 0, 0, 0, 0, 1, 0,  0, 0, 0},
		'{0, rebi_pkg::REG_DIR_INVERT, 0, 0, 0, 1, 0, 0,  0, 0, 0},
		'{0, rebi_pkg::REG_DIR_INVERT, 0, 0, 0, 1, 1, 0,  0, 0, 0},
		'{0, rebi_pkg::REG_DIR_INVERT, 0, 0, 0, 1, 1, 1,  0, 0, 0},
		'{1, rebi_pkg::REG_DIR_INVERT, 1, 0, 0, 1, 0, 0,  0, 0, 0},
		'{1, rebi_pkg::REG_LONG_TICKS, 1, 0, 0, 1, 0, 0,  0, 0, 0},
		'{0, rebi_pkg::REG_DIR_INVERT, 0, 1, 0, 1, 1, 1, -1, 0, 0},
		'{0, rebi_pkg::REG_DIR_INVERT, 0, 0, 0, 0, 1, 0,  0, 0, 0},
		'{0, rebi_pkg::REG_DIR_INVERT, 0, 0, 0, 0, 1, 0,  0, 0, 0},
		'{0, rebi_pkg::REG_DIR_INVERT, 0, 0, 0, 0, 1, 0,  0, 0, 0},
		'{0, rebi_pkg::REG_DIR_INVERT, 0, 0, 0, 1, 1, 1,  0, 0, 0},
		'{0, rebi_pkg::REG_DIR_INVERT, 0, 0, 0, 0, 0, 0,  0, 0, 0},
		'{0, rebi_pkg::REG_DIR_INVERT, 0, 0, 0, 1, 1, 0,  0, 0, 0}
	};

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic longint sat_add(longint v, longint d);
		longint s;
		s = v + d;
		if (s > ACC_MAX) s = ACC_MAX;
		if (s < ACC_MIN) s = ACC_MIN;
		return s;
	endfunction

	function automatic tick_result_t encoder_tick(bit a, bit b, bit btn, bit q);
		tick_result_t r;
		longint       dir;
		dir = cfg_invert ? -1 : 1;
		if (a != trk_a) begin
			trk_a = a;
			if (trk_a && !trk_b) step_acc = sat_add(step_acc, dir);
		end
		if (b != trk_b) begin
			trk_b = b;
			if (trk_b && !trk_a) step_acc = sat_add(step_acc, -dir);
		end
		if (btn_prev && !btn) begin
			hold_cnt = '0;
		end else begin
			if (hold_cnt != '1) hold_cnt = hold_cnt + rebi_pkg::TICK_WIDTH_DEF'(1);
			if (!btn_prev && btn) begin
				short_flag  = !short_block;
				short_block = 0;
			end
		end
		btn_prev      = btn;
		r.step_count  = rebi_pkg::STEP_W'(step_acc);
		r.short_press = short_flag;
		r.long_press  = 1'b0;
		if (q) begin
			if (!btn && hold_cnt >= cfg_long_ticks) begin
				r.long_press = 1'b1;
				hold_cnt     = '1;
				short_block  = 1;
			end
			step_acc   = 0;
			short_flag = 0;
		end
		return r;
	endfunction

	task automatic send_item(input bit a, input bit b, input bit btn, input bit q,
		input bit pinned, input tick_result_t pinned_val);
		tick_result_t want;
		int           gap;
		gap = fast_mode ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			sample_if.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		sample_if.line_a       = a;
		sample_if.line_b       = b;
		sample_if.button_level = btn;
		sample_if.query        = q;
		sample_if.valid        = 1'b1;
		@(posedge clk);
		while (!sample_if.ready) @(posedge clk);
		want = encoder_tick(a, b, btn, q);
		pending_reports.push_back(pinned ? pinned_val : want);
		@(negedge clk);
	endtask

	task automatic send_tick(input bit a, input bit b, input bit btn, input bit q);
		send_item(a, b, btn, q, 1'b0, '0);
	endtask

	task automatic settle();
		sample_if.valid = 1'b0;
		while (pending_reports.size() != 0) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic reg_write(input rebi_pkg::reg_idx_t idx, input int unsigned val);
		logic [rebi_pkg::APB_DATA_W-1:0] mask;
		logic [rebi_pkg::APB_DATA_W-1:0] rd;
		mask    = (idx == rebi_pkg::REG_DIR_INVERT) ? rebi_pkg::APB_DATA_W'(1)
			: rebi_pkg::APB_DATA_W'(16'hFFFF);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = rebi_pkg::APB_ADDR_W'(4 * int'(idx));
		pwdata  = rebi_pkg::APB_DATA_W'(val);
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		@(negedge clk);
		penable = 1'b0;
		pwrite  = 1'b0;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		rd = prdata;
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		if (idx == rebi_pkg::REG_DIR_INVERT) cfg_invert = val[0];
		else cfg_long_ticks = val[rebi_pkg::LP_TICKS_W-1:0];
		if ((rd & mask) !== (rebi_pkg::APB_DATA_W'(val) & mask)) begin
			$error("register %s readback: expected %0d, got %0d", idx.name(),
				rebi_pkg::APB_DATA_W'(val) & mask, rd & mask);
			errors++;
		end
	endtask

	// Sweeps the count SWEEP_STEPS steps up, then down, with the button held under a 65534-tick threshold.
	task automatic run_extremes();
		fast_mode = 1;
		send_tick(0, 0, 0, 0);
		repeat (SWEEP_STEPS) begin
			send_tick(1, 0, 0, 0);
			send_tick(0, 0, 0, 0);
		end
		send_tick(0, 0, 0, 1);
		repeat (SWEEP_STEPS) begin
			send_tick(0, 1, 0, 0);
			send_tick(0, 0, 0, 0);
		end
		send_tick(0, 0, 0, 1);
		send_tick(0, 0, 1, 1);
		fast_mode = 0;
	endtask

	task automatic run_random(input int count);
		int pos;
		bit fwd;
		bit a;
		bit b;
		bit btn;
		bit q;
		int pick;
		a   = trk_a;
		b   = trk_b;
		btn = btn_prev;
		fwd = 1;
		for (int i = 0; i < count; i++) begin
			if (i % 64 == 0) fast_mode = ($urandom_range(0, 3) == 0);
			pos  = a ? (b ? 2 : 1) : (b ? 3 : 0);
			pick = $urandom_range(0, 9);
			if ($urandom_range(0, 15) == 0) fwd = !fwd;
			if (pick == 0) begin
				a = 1'($urandom_range(0, 1));
				b = 1'($urandom_range(0, 1));
			end else if (pick > 2) begin
				pos = fwd ? (pos + 1) % 4 : (pos + 3) % 4;
				a   = (pos == 1) || (pos == 2);
				b   = (pos == 2) || (pos == 3);
			end
			if (btn ? ($urandom_range(0, 11) == 0) : ($urandom_range(0, 39) == 0)) btn = !btn;
			q = ($urandom_range(0, 3) == 0);
			send_tick(a, b, btn, q);
		end
		fast_mode = 0;
	endtask

	initial begin : result_sink
		tick_result_t want;
		int           stall;
		result_if.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = fast_mode ? 0 : $urandom_range(0, 15);
			if (hold_off_req) begin
				hold_off_req = 0;
				stall        = 400;
			end
			if (stall > 0) begin
				result_if.ready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			result_if.ready = 1'b1;
			@(posedge clk);
			while (!result_if.valid) @(posedge clk);
			if (pending_reports.size() == 0) begin
				$error("result item arrived with no sample outstanding");
				errors++;
			end else begin
				want = pending_reports.pop_front();
				if (result_if.step_count !== want.step_count) begin
					$error("step_count: expected %0d, got %0d", want.step_count,
						result_if.step_count);
					errors++;
				end
				if (result_if.short_press !== want.short_press) begin
					$error("short_press: expected %0b, got %0b", want.short_press,
						result_if.short_press);
					errors++;
				end
				if (result_if.long_press !== want.long_press) begin
					$error("long_press: expected %0b, got %0b", want.long_press,
						result_if.long_press);
					errors++;
				end
			end
			@(negedge clk);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((sample_if.valid && sample_if.ready) || (result_if.valid && result_if.ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= STALL_LIMIT) begin
				$display("rotary_encoder_button_interface regression: fail");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	initial begin : stimulus
		tick_result_t pin;
		arst_n                 = 1'b0;
		psel                   = 1'b0;
		penable                = 1'b0;
		pwrite                 = 1'b0;
		paddr                  = '0;
		pwdata                 = '0;
		sample_if.valid        = 1'b0;
		sample_if.line_a       = 1'b0;
		sample_if.line_b       = 1'b0;
		sample_if.button_level = 1'b1;
		sample_if.query        = 1'b0;
		cfg_invert             = 0;
		cfg_long_ticks         = rebi_pkg::LP_TICKS_RESET;
		trk_a                  = 0;
		trk_b                  = 0;
		btn_prev               = 1;
		step_acc               = 0;
		short_flag             = 0;
		short_block            = 0;
		hold_cnt               = '1;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		foreach (plan[i]) begin
			if (plan[i].is_cfg) begin
				settle();
				reg_write(plan[i].idx, plan[i].val);
			end else begin
				pin.step_count  = rebi_pkg::STEP_W'(plan[i].step);
				pin.short_press = plan[i].sp;
				pin.long_press  = plan[i].lp;
				send_item(plan[i].a, plan[i].b, plan[i].btn, plan[i].q, plan[i].pinned, pin);
			end
		end

		settle();
		reg_write(rebi_pkg::REG_DIR_INVERT, 0);
		reg_write(rebi_pkg::REG_LONG_TICKS, 65534);
		run_extremes();

		for (int phase = 0; phase < 3; phase++) begin
			settle();
			reg_write(rebi_pkg::REG_DIR_INVERT, phase % 2);
			reg_write(rebi_pkg::REG_LONG_TICKS,
				(phase == 0) ? 1 : $urandom_range(2, 30 * phase));
			if (phase == 1) hold_off_req = 1;
			run_random(RANDOM_ITEMS);
		end

		sample_if.valid = 1'b0;
		while (pending_reports.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		if (errors == 0) begin
			$display("rotary_encoder_button_interface regression: pass");
		end else begin
			$display("rotary_encoder_button_interface regression: fail");
		end
		$finish;
	end

endmodule
